/* rtl/positional_array_list_assert.svh */
// ----------------------------------------------------------------------------
// positional_array_list_assert.svh
// Assertion macros for the positional array list RTL, used by pal_ctrl.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define PAL_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Overlapping implication: when ante holds, cons holds in the same cycle.
`define PAL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg
// Types and codes for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DEF_CAPACITY = 128;

    localparam logic [1:0] ACT_GET    = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         position;
        logic signed [31:0] new_value;
    } pal_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [7:0]         count;
        logic               is_empty;
    } pal_rsp_t;

endpackage

/* rtl/pal_store.sv */
// ----------------------------------------------------------------------------
// pal_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pal_store
    import pal_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int AW = $clog2(CAPACITY)
)
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [31:0]  rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data
);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/pal_ctrl.sv */
// ----------------------------------------------------------------------------
// pal_ctrl
// Request sequencer: range checks, list length, and the one-entry-per-cycle
// shift engine that moves entries through the element memory.
// ----------------------------------------------------------------------------
`include "positional_array_list_assert.svh"

module pal_ctrl
    import pal_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int AW = $clog2(CAPACITY),
    localparam int LW = $clog2(CAPACITY + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pal_req_t            req,
    output logic                res_valid,
    input  logic                res_take,
    output pal_rsp_t            res,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic signed [31:0]  rd_data,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic signed [31:0]  wr_data
);

    // compare width covers both the 8-bit position and the length
    localparam int CW = ((LW > 8) ? LW : 8) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIRST = 5'b00010,
        S_SHIFT = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [1:0]         act_reg, act_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] readv_reg, readv_next;
    logic [AW-1:0]      pa_reg, pa_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      wadr_reg, wadr_next;
    logic [LW-1:0]      rem_reg, rem_next;
    logic               pend_reg, pend_next;

    logic [CW-1:0]      pos_ext;
    logic [CW-1:0]      len_ext;
    logic               in_take;
    logic               pos_ok_rd;
    logic               pos_ok_ins;
    logic               full;

    assign pos_ext    = CW'(req.position);
    assign len_ext    = CW'(len_reg);
    assign in_take    = req_valid && (state_reg == S_IDLE);
    assign req_stall  = (state_reg != S_IDLE);
    assign pos_ok_rd  = (req.position != 8'd0) && (pos_ext <= len_ext);
    assign pos_ok_ins = (req.position != 8'd0) && (pos_ext <= len_ext + CW'(1));
    assign full       = (len_reg == LW'(CAPACITY));

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        act_next    = act_reg;
        status_next = status_reg;
        val_next    = val_reg;
        readv_next  = readv_reg;
        pa_next     = pa_reg;
        ptr_next    = ptr_reg;
        wadr_next   = wadr_reg;
        rem_next    = rem_reg;
        pend_next   = pend_reg;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg;
        wr_en       = 1'b0;
        wr_addr     = wadr_reg;
        wr_data     = rd_data;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    act_next    = req.action;
                    val_next    = req.new_value;
                    readv_next  = '0;
                    status_next = ST_OK;
                    pa_next     = AW'(pos_ext - CW'(1));
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                    case (req.action)
                        ACT_GET:
                        begin
                            if (pos_ok_rd)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pos_ext - CW'(1));
                                state_next = S_FIRST;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (!pos_ok_ins)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // move entries pos..len up, last one first
                                ptr_next   = AW'(len_ext - CW'(1));
                                rem_next   = LW'(len_ext - pos_ext + CW'(1));
                                len_next   = len_reg + LW'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (pos_ok_rd)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pos_ext - CW'(1));
                                // move entries pos+1..len down, first one first
                                ptr_next   = AW'(pos_ext);
                                rem_next   = LW'(len_ext - pos_ext);
                                len_next   = len_reg - LW'(1);
                                state_next = S_FIRST;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            len_next = '0;
                        end
                    endcase
                end
            end
            S_FIRST:
            begin
                readv_next = rd_data;
                state_next = (act_reg == ACT_GET) ? S_DONE : S_SHIFT;
            end
            S_SHIFT:
            begin
                // write back what was read last cycle, read the next entry
                wr_en = pend_reg;
                if (rem_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rem_next  = rem_reg - LW'(1);
                    pend_next = 1'b1;
                    if (act_reg == ACT_INSERT)
                    begin
                        ptr_next  = ptr_reg - AW'(1);
                        wadr_next = ptr_reg + AW'(1);
                    end
                    else
                    begin
                        ptr_next  = ptr_reg + AW'(1);
                        wadr_next = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = (act_reg == ACT_INSERT) ? S_PLACE : S_DONE;
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pa_reg;
                wr_data    = val_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        readv_reg  <= readv_next;
        pa_reg     <= pa_next;
        ptr_reg    <= ptr_next;
        wadr_reg   <= wadr_next;
        rem_reg    <= rem_next;
    end

    assign res.status     = status_reg;
    assign res.read_value = readv_reg;
    assign res.count      = 8'(len_reg);
    assign res.is_empty   = (len_reg == '0);

    `PAL_ASSERT_IMP(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr, "read and write hit one entry")
    `PAL_ASSERT(a_len_bound, len_reg <= LW'(CAPACITY), "list length beyond capacity")
    `PAL_ASSERT_IMP(a_write_state, wr_en, (state_reg == S_SHIFT) || (state_reg == S_PLACE), "memory write outside shift or place")
    `PAL_ASSERT_NEXT(a_done_idle, res_valid && res_take, state_reg == S_IDLE, "sequencer not idle after result")

endmodule

/* rtl/positional_array_list.sv */
// Request to result: get reads the entry; insert shifts entries pos..len up, then writes
// the new value; delete reads the entry, then shifts pos+1..len down; a failed request or
// clear goes straight to the result. One result register follows. One request at a time;
// the shift engine moves one entry per cycle through the single-port-each-way element memory.
// Reset: list length cleared to zero; element memory is not cleared (no sweep needed).
// ----------------------------------------------------------------------------
// positional_array_list
// Fixed-capacity ordered list with get, insert, delete and clear by position.
// ----------------------------------------------------------------------------
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  pal_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output pal_rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic               res_valid;
    logic               res_take;
    pal_rsp_t           res;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    logic               rsp_valid_reg, rsp_valid_next;
    pal_rsp_t           rsp_reg;

    pal_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    pal_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // result register: loads when empty or being drained this cycle
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* tb/positional_array_list_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_checker
// Watches both channels of the array list, keeps a shadow copy of the list,
// predicts the result of every accepted request and compares each result
// field by field, in order.
// ----------------------------------------------------------------------------
module positional_array_list_checker
    import pal_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  pal_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  pal_rsp_t rsp,
    output int       mismatches,
    output int       outstanding
);

    logic signed [31:0] list_words [CAPACITY];
    int                 list_len;
    pal_rsp_t           awaited_results [$];

    // Updates the shadow list for one request and forms its result.
    task automatic apply_request(input pal_req_t r, output pal_rsp_t res);
        int pos;
        int k;
        pos = r.position;
        res = '0;
        res.status = ST_OK;
        case (r.action)
            ACT_GET:
            begin
                if (pos < 1 || pos > list_len)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_words[pos - 1];
            end
            ACT_INSERT:
            begin
                // position is checked before the full condition
                if (pos < 1 || pos > list_len + 1)
                    res.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (k = list_len; k >= pos; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[pos - 1] = r.new_value;
                    list_len++;
                end
            end
            ACT_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    res.status = ST_RANGE;
                else
                begin
                    res.read_value = list_words[pos - 1];
                    for (k = pos; k < list_len; k++)
                        list_words[k - 1] = list_words[k];
                    list_len--;
                end
            end
            default:
                list_len = 0;
        endcase
        res.count    = 8'(list_len);
        res.is_empty = (list_len == 0);
    endtask

    task automatic check_field(input string name, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        pal_rsp_t want;
        pal_rsp_t predicted;
        if (!rst_n)
        begin
            list_len = 0;
            awaited_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            // a result never belongs to a request accepted in the same cycle
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d value %0d",
                           rsp.status, rsp.read_value);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("read_value", want.read_value, rsp.read_value);
                    check_field("count", want.count, rsp.count);
                    check_field("is_empty", want.is_empty, rsp.is_empty);
                end
            end
            if (req_valid && !req_stall)
            begin
                apply_request(req, predicted);
                awaited_results.push_back(predicted);
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives get, insert, delete and clear requests into the array list: a
// directed opening over the edge cases, then random traffic that fills the
// list to capacity, works on the full list and then mixes everything at
// smaller lengths. Both channels idle at random; the result side holds off
// for long stretches so the block backs up.
// ----------------------------------------------------------------------------
module testbench;
    import pal_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = CAPACITY + 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 250;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    pal_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    pal_rsp_t rsp;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int results_taken = 0;
    int tracked_len = 0;    // list length as seen by the stimulus, steers positions
    bit quiet_send = 1'b0;
    bit quiet_recv = 1'b0;

    positional_array_list #(.CAPACITY(CAPACITY)) dut (
        clk, rst_n, req_valid, req_stall, req, rsp_valid, rsp_stall, rsp
    );

    positional_array_list_checker #(.CAPACITY(CAPACITY)) list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] pos,
                             input logic signed [31:0] val);
        int gap;
        if ($urandom_range(0, 15) == 0)
            quiet_send = !quiet_send;
        gap = quiet_send ? 0 : $urandom_range(0, 6);
        repeat (gap) @(negedge clk) req_valid <= 1'b0;
        @(negedge clk);
        req_valid <= 1'b1;
        req <= '{action: act, position: pos, new_value: val};
        do @(posedge clk); while (!(req_valid && !req_stall));
        case (act)
            ACT_INSERT:
                if (pos >= 1 && pos <= tracked_len + 1 && tracked_len < CAPACITY)
                    tracked_len++;
            ACT_DELETE:
                if (pos >= 1 && pos <= tracked_len)
                    tracked_len--;
            ACT_CLEAR:
                tracked_len = 0;
            default:
                ;
        endcase
    endtask

    // Mostly a valid position, often an end one, sometimes anything at all.
    function automatic logic [7:0] pick_pos(input int hi);
        if (hi < 1 || $urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: return 8'd1;
            1: return 8'(hi);
            default: return 8'($urandom_range(1, hi));
        endcase
    endfunction

    // Weights in percent; the rest is noise with any action and position.
    task automatic random_item(input int w_ins, input int w_get, input int w_del);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            send_item(ACT_INSERT, pick_pos(tracked_len + 1), $urandom());
        else if (r < w_ins + w_get)
            send_item(ACT_GET, pick_pos(tracked_len), $urandom());
        else if (r < w_ins + w_get + w_del)
            send_item(ACT_DELETE, pick_pos(tracked_len), $urandom());
        else
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom());
    endtask

    initial
    begin : take_results
        int gap;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                quiet_recv = !quiet_recv;
            gap = quiet_recv ? 0 : $urandom_range(0, 6);
            // long hold-off while requests keep coming, so the block backs up
            if (results_taken == 40 || results_taken == 300)
                gap = LONG_HOLD;
            repeat (gap) @(negedge clk) rsp_stall <= 1'b1;
            @(negedge clk) rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            results_taken++;
        end
    end

    initial
    begin : stimulus
        int sent;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // empty list, bad positions
        send_item(ACT_GET,    8'd1,   32'sd7);
        send_item(ACT_DELETE, 8'd1,   32'sd7);
        send_item(ACT_INSERT, 8'd0,   32'sd7);
        send_item(ACT_INSERT, 8'd2,   32'sd7);
        // build a short list: append, front and middle inserts
        send_item(ACT_INSERT, 8'd1,   32'sh8000_0000);
        send_item(ACT_INSERT, 8'd2,   32'sh7FFF_FFFF);
        send_item(ACT_INSERT, 8'd1,   -32'sd1);
        send_item(ACT_INSERT, 8'd2,   32'sd0);
        send_item(ACT_GET,    8'd4,   32'sd0);
        send_item(ACT_GET,    8'd5,   32'sd0);
        send_item(ACT_GET,    8'd255, 32'sd0);
        send_item(ACT_GET,    8'd0,   32'sd0);
        send_item(ACT_INSERT, 8'd6,   32'sd9);
        send_item(ACT_DELETE, 8'd2,   32'sd0);
        send_item(ACT_DELETE, 8'd3,   32'sd0);
        send_item(ACT_DELETE, 8'd0,   32'sd0);
        send_item(ACT_GET,    8'd1,   32'sd0);
        send_item(ACT_CLEAR,  8'd0,   32'sd0);
        send_item(ACT_GET,    8'd1,   32'sd0);
        send_item(ACT_INSERT, 8'd1,   32'sh5555_5555);
        send_item(ACT_INSERT, 8'd1,   32'shAAAA_AAAA);
        send_item(ACT_CLEAR,  8'd255, -32'sd1);
        send_item(ACT_DELETE, 8'd128, 32'sd0);

        sent = 0;
        // fill the list up to capacity
        while (tracked_len < CAPACITY && sent < 300)
        begin
            random_item(85, 10, 5);
            sent++;
        end
        // full list: valid inserts must report full
        repeat (16)
        begin
            random_item(60, 30, 10);
            sent++;
        end
        // mixed traffic, drifting toward short lists
        while (sent < RANDOM_ITEMS)
        begin
            random_item(30, 30, 36);
            sent++;
        end

        @(negedge clk) req_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* positional_array_list.f */
+incdir+rtl
rtl/pal_pkg.sv
rtl/pal_store.sv
rtl/pal_ctrl.sv
rtl/positional_array_list.sv
tb/positional_array_list_checker.sv
tb/testbench.sv
